// ===== design/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants
// Item kinds, register indexes and default settings of the FSK period
// demodulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

  localparam int unsigned TimeBitsDef = 16;
  localparam int unsigned RunBitsDef  = 8;
  localparam int unsigned StatBitsDef = 32;

  localparam int unsigned BitCountW = 9;
  localparam int unsigned PulseW    = 8;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned ShortTimeRst   = 64;
  localparam int unsigned ShortPulsesRst = 6;
  localparam int unsigned LongTimeRst    = 80;
  localparam int unsigned LongPulsesRst  = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_TIME   = 2'd0,
    REG_SHORT_PULSES = 2'd1,
    REG_LONG_TIME    = 2'd2,
    REG_LONG_PULSES  = 2'd3
  } reg_idx_e;

  // classification of a segment by the front end
  typedef enum logic [1:0] {
    KIND_HIGH   = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_LONG   = 2'd2,
    KIND_NORMAL = 2'd3
  } kind_e;

  localparam int unsigned KindW = 2;

endpackage

`default_nettype wire

// ===== design/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div: restoring divider
// One quotient bit per cycle, unsigned dividend by an 8-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_div #(
  parameter int unsigned DW = 19
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [DW-1:0]              dividend_i,
  input  wire logic [fpd_pkg::PulseW-1:0] divisor_i,
  output logic                            done_o,
  output logic [DW-1:0]                   quotient_o
);
  import fpd_pkg::*;

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]     dvd_q, dvd_d;
  logic [PulseW-1:0] rem_q, rem_d;
  logic [PulseW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [PulseW:0]   rem_sh;
  logic [PulseW:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[PulseW-1:0] : rem_sh[PulseW-1:0];
      dvd_d = {dvd_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// ===== design/fpd_front.sv =====
// ----------------------------------------------------------------------------
// fpd_front: segment intake
// Rebuild the carrier period from segments and classify it against limits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_front #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic                   line_level_i,
  input  wire logic [TIME_BITS-1:0]   segment_length_i,
  input  wire logic [TIME_BITS-1:0]   lo_t_i,
  input  wire logic [TIME_BITS-1:0]   hi_t_i,
  output fpd_pkg::kind_e              kind_o,
  output logic [TIME_BITS+1:0]        sum_o
);
  import fpd_pkg::*;

  localparam int unsigned SW = TIME_BITS + 2;

  logic [SW-1:0] sum_q, sum_d;
  logic [SW:0]   sum_ext;

  assign sum_ext = {1'b0, sum_q} + (SW + 1)'(segment_length_i);

  always_comb begin
    if (line_level_i) begin
      sum_d = SW'(segment_length_i);
    end else if (sum_ext[SW]) begin
      sum_d = '1;
    end else begin
      sum_d = sum_ext[SW-1:0];
    end
  end

  always_comb begin
    if (line_level_i) begin
      kind_o = KIND_HIGH;
    end else if (sum_d < SW'(lo_t_i)) begin
      kind_o = KIND_SHORT;
    end else if (sum_d >= SW'(hi_t_i)) begin
      kind_o = KIND_LONG;
    end else begin
      kind_o = KIND_NORMAL;
    end
  end

  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fpd_fifo.sv =====
// ----------------------------------------------------------------------------
// fpd_fifo: two-entry queue
// Decouple the intake from the period processor.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_fifo #(
  parameter int unsigned W = 20
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);
  import fpd_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== design/fpd_back.sv =====
// ----------------------------------------------------------------------------
// fpd_back: period processor
// Recover over-long periods, track runs, decode bits and keep tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_back #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned RUN_BITS  = 8,
  parameter int unsigned STAT_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  fpd_pkg::kind_e                   kind_i,
  input  wire logic [TIME_BITS+1:0]        sum_i,
  output logic                             pop_o,
  input  wire logic [TIME_BITS-1:0]        lo_t_i,
  input  wire logic [TIME_BITS-1:0]        hi_t_i,
  input  wire logic [TIME_BITS-1:0]        mid_t_i,
  input  wire logic [fpd_pkg::PulseW-1:0]  lo_p_i,
  input  wire logic [fpd_pkg::PulseW-1:0]  hi_p_i,
  input  wire logic                        inv_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [fpd_pkg::BitCountW-1:0]    bit_count_o,
  output logic                             bit_value_o,
  output logic                             transition_seen_o,
  output logic [STAT_BITS-1:0]             count_short_rejects_o,
  output logic [STAT_BITS-1:0]             count_long_rejects_o,
  output logic [STAT_BITS-1:0]             count_long_recovered_o,
  output logic [STAT_BITS-1:0]             count_accepted_o,
  output logic [STAT_BITS-1:0]             count_high_class_o,
  output logic [STAT_BITS-1:0]             count_low_class_o,
  output logic [STAT_BITS-1:0]             count_transitions_o
);
  import fpd_pkg::*;

  localparam int unsigned SW = TIME_BITS + 2;
  localparam int unsigned CW = TIME_BITS + 3;
  localparam int unsigned DW = (RUN_BITS + 1 > BitCountW) ? RUN_BITS + 1 : BitCountW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_TRY  = 6'b000100,
    S_TAKE = 6'b001000,
    S_BITS = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SW-1:0]        sum_q, sum_d;
  logic [2:0]           r_q, r_d;
  logic                 cls_q, cls_d;
  logic [RUN_BITS-1:0]  run_q, run_d;
  logic                 last_q, last_d;
  logic [BitCountW-1:0] bits_q, bits_d;
  logic                 val_q, val_d;
  logic                 seen_q, seen_d;
  logic [STAT_BITS-1:0] srej_q, srej_d, lrej_q, lrej_d, rec_q, rec_d;
  logic [STAT_BITS-1:0] acc_q, acc_d, hic_q, hic_d, loc_q, loc_d, trn_q, trn_d;

  logic                 out_valid_q;
  logic                 load_out;

  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [PulseW-1:0]    div_divisor;
  logic                 div_done;
  logic [DW-1:0]        quot;

  logic [RUN_BITS:0]    run_inc1;
  logic [RUN_BITS-1:0]  run_sat1;
  logic [RUN_BITS:0]    run_incr;
  logic [2:0]           r_next;

  // rounded quotient q = (sum + r/2) / r is tested without dividing:
  // q >= t exactly when sum + r/2 >= r*t
  logic [CW-1:0]        try_num;
  logic [CW-1:0]        try_lo;
  logic [CW-1:0]        try_hi;
  logic [CW-1:0]        try_mid;
  logic                 q_in_range;
  logic                 q_cls;

  function automatic logic [CW-1:0] scale_by_r(input logic [TIME_BITS-1:0] t,
                                               input logic [2:0] r);
    logic [CW-1:0] t1;
    logic [CW-1:0] res;
    t1 = CW'(t);
    case (r)
      3'd2:    res = t1 << 1;
      3'd3:    res = t1 + (t1 << 1);
      default: res = t1 << 2;
    endcase
    return res;
  endfunction

  fpd_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign run_inc1   = {1'b0, run_q} + (RUN_BITS + 1)'(1);
  assign run_sat1   = run_inc1[RUN_BITS] ? '1 : run_inc1[RUN_BITS-1:0];
  assign run_incr   = {1'b0, run_q} + (RUN_BITS + 1)'(r_q);
  assign r_next     = r_q + 3'd1;

  assign try_num    = CW'(sum_q) + CW'(r_q >> 1);
  assign try_lo     = scale_by_r(lo_t_i, r_q);
  assign try_hi     = scale_by_r(hi_t_i, r_q);
  assign try_mid    = scale_by_r(mid_t_i, r_q);
  assign q_in_range = (try_num >= try_lo) && (try_num < try_hi);
  assign q_cls      = try_num >= try_mid;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign load_out = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    r_d          = r_q;
    cls_d        = cls_q;
    run_d        = run_q;
    last_d       = last_q;
    bits_d       = bits_q;
    val_d        = val_q;
    seen_d       = seen_q;
    srej_d       = srej_q;
    lrej_d       = lrej_q;
    rec_d        = rec_q;
    acc_d        = acc_q;
    hic_d        = hic_q;
    loc_d        = loc_q;
    trn_d        = trn_q;
    div_start    = 1'b0;
    div_dividend = DW'(run_sat1) + DW'(2);
    div_divisor  = last_q ? hi_p_i : lo_p_i;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          sum_d  = sum_i;
          bits_d = '0;
          val_d  = 1'b0;
          seen_d = 1'b0;
          case (kind_i)
            KIND_HIGH: begin
              state_d = S_EMIT;
            end
            KIND_SHORT: begin
              srej_d  = srej_q + STAT_BITS'(1);
              run_d   = '0;
              state_d = S_EMIT;
            end
            KIND_NORMAL: begin
              cls_d   = sum_i >= SW'(mid_t_i);
              r_d     = 3'd1;
              state_d = S_TAKE;
            end
            KIND_LONG: begin
              r_d     = 3'd2;
              state_d = S_TRY;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_BITS;
      end
      S_TRY: begin
        if (q_in_range) begin
          cls_d   = q_cls;
          rec_d   = rec_q + STAT_BITS'(1);
          state_d = S_TAKE;
        end else if (r_q == 3'd4) begin
          lrej_d  = lrej_q + STAT_BITS'(1);
          run_d   = '0;
          state_d = S_EMIT;
        end else begin
          // try the next divisor
          r_d = r_next;
        end
      end
      S_TAKE: begin
        acc_d = acc_q + STAT_BITS'(r_q);
        if (cls_q) hic_d = hic_q + STAT_BITS'(r_q);
        else       loc_d = loc_q + STAT_BITS'(r_q);
        if (cls_q == last_q) begin
          run_d   = run_incr[RUN_BITS] ? '1 : run_incr[RUN_BITS-1:0];
          state_d = S_EMIT;
        end else begin
          trn_d     = trn_q + STAT_BITS'(1);
          seen_d    = 1'b1;
          val_d     = last_q ? !inv_i : inv_i;
          run_d     = RUN_BITS'(r_q - 3'd1);
          last_d    = cls_q;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_BITS: begin
        bits_d  = quot[BitCountW-1:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      last_q      <= 1'b0;
      srej_q      <= '0;
      lrej_q      <= '0;
      rec_q       <= '0;
      acc_q       <= '0;
      hic_q       <= '0;
      loc_q       <= '0;
      trn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_q      <= run_d;
      last_q     <= last_d;
      srej_q     <= srej_d;
      lrej_q     <= lrej_d;
      rec_q      <= rec_d;
      acc_q      <= acc_d;
      hic_q      <= hic_d;
      loc_q      <= loc_d;
      trn_q      <= trn_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    r_q    <= r_d;
    cls_q  <= cls_d;
    bits_q <= bits_d;
    val_q  <= val_d;
    seen_q <= seen_d;
    if (load_out) begin
      bit_count_o            <= bits_q;
      bit_value_o            <= val_q;
      transition_seen_o      <= seen_q;
      count_short_rejects_o  <= srej_q;
      count_long_rejects_o   <= lrej_q;
      count_long_recovered_o <= rec_q;
      count_accepted_o       <= acc_q;
      count_high_class_o     <= hic_q;
      count_low_class_o      <= loc_q;
      count_transitions_o    <= trn_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/fsk_period_demodulator.sv =====
// ----------------------------------------------------------------------------
// fsk_period_demodulator: period-counting FSK receiver
// Rebuilds carrier periods from timed segments and decodes data bits.
// ----------------------------------------------------------------------------
// Path from an accepted segment to out_valid_o: a high or rejected-short
// segment goes from the queue straight to the emit state, a period in range
// passes the take state first, an over-long period first runs up to three
// recovery trials, and a tone change adds the bit-serial bit-count division
// (DW = 9 by default). The processor takes one item at a time, a two-entry
// queue lets intake run ahead. Reset: clear state and tallies.
`default_nettype none

module fsk_period_demodulator #(
  parameter int unsigned TIME_BITS = fpd_pkg::TimeBitsDef,
  parameter int unsigned RUN_BITS  = fpd_pkg::RunBitsDef,
  parameter int unsigned STAT_BITS = fpd_pkg::StatBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [fpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [TIME_BITS-1:0]         cfg_data_i,
  // segment requests
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         line_level_i,
  input  wire logic [TIME_BITS-1:0]         segment_length_i,
  // result requests
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [fpd_pkg::BitCountW-1:0]     bit_count_o,
  output logic                              bit_value_o,
  output logic                              transition_seen_o,
  output logic [STAT_BITS-1:0]              count_short_rejects_o,
  output logic [STAT_BITS-1:0]              count_long_rejects_o,
  output logic [STAT_BITS-1:0]              count_long_recovered_o,
  output logic [STAT_BITS-1:0]              count_accepted_o,
  output logic [STAT_BITS-1:0]              count_high_class_o,
  output logic [STAT_BITS-1:0]              count_low_class_o,
  output logic [STAT_BITS-1:0]              count_transitions_o
);
  import fpd_pkg::*;

  localparam int unsigned SW = TIME_BITS + 2;
  localparam int unsigned IW = SW + KindW;

  // configuration registers
  logic [TIME_BITS-1:0] short_t_q, long_t_q;
  logic [PulseW-1:0]    short_p_q, long_p_q;

  // working tone settings after the swap
  logic [TIME_BITS-1:0] lo_t, hi_t, mid_t, span;
  logic [PulseW-1:0]    lo_p, hi_p;
  logic                 inv;

  logic                 in_accept;
  kind_e                front_kind;
  logic [SW-1:0]        front_sum;
  logic                 fifo_full, fifo_empty, fifo_pop;
  logic [IW-1:0]        fifo_out;
  kind_e                back_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_t_q <= TIME_BITS'(ShortTimeRst);
      short_p_q <= PulseW'(ShortPulsesRst);
      long_t_q  <= TIME_BITS'(LongTimeRst);
      long_p_q  <= PulseW'(LongPulsesRst);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SHORT_TIME:   short_t_q <= cfg_data_i;
        REG_SHORT_PULSES: short_p_q <= cfg_data_i[PulseW-1:0];
        REG_LONG_TIME:    long_t_q  <= cfg_data_i;
        REG_LONG_PULSES:  long_p_q  <= cfg_data_i[PulseW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Swap the tones when given the wrong way round; that turns on invert
  // mode. A zero pulses-per-bit setting counts as one.
  always_comb begin
    inv  = short_t_q > long_t_q;
    lo_t = inv ? long_t_q : short_t_q;
    hi_t = inv ? short_t_q : long_t_q;
    lo_p = inv ? long_p_q : short_p_q;
    hi_p = inv ? short_p_q : long_p_q;
    if (lo_p == '0) lo_p = PulseW'(1);
    if (hi_p == '0) hi_p = PulseW'(1);
  end

  assign span  = hi_t - lo_t;
  assign mid_t = lo_t + (span >> 1);

  // hold off new segments while the queue is full
  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i && !fifo_full;

  fpd_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .line_level_i     (line_level_i),
    .segment_length_i (segment_length_i),
    .lo_t_i           (lo_t),
    .hi_t_i           (hi_t),
    .kind_o           (front_kind),
    .sum_o            (front_sum)
  );

  fpd_fifo #(
    .W (IW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  ({front_kind, front_sum}),
    .pop_i   (fifo_pop),
    .data_o  (fifo_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  assign back_kind = kind_e'(fifo_out[IW-1:SW]);

  fpd_back #(
    .TIME_BITS (TIME_BITS),
    .RUN_BITS  (RUN_BITS),
    .STAT_BITS (STAT_BITS)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .empty_i                (fifo_empty),
    .kind_i                 (back_kind),
    .sum_i                  (fifo_out[SW-1:0]),
    .pop_o                  (fifo_pop),
    .lo_t_i                 (lo_t),
    .hi_t_i                 (hi_t),
    .mid_t_i                (mid_t),
    .lo_p_i                 (lo_p),
    .hi_p_i                 (hi_p),
    .inv_i                  (inv),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .bit_count_o            (bit_count_o),
    .bit_value_o            (bit_value_o),
    .transition_seen_o      (transition_seen_o),
    .count_short_rejects_o  (count_short_rejects_o),
    .count_long_rejects_o   (count_long_rejects_o),
    .count_long_recovered_o (count_long_recovered_o),
    .count_accepted_o       (count_accepted_o),
    .count_high_class_o     (count_high_class_o),
    .count_low_class_o      (count_low_class_o),
    .count_transitions_o    (count_transitions_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_fsk_period_demodulator.sv =====
// ----------------------------------------------------------------------------
// tb_fsk_period_demodulator: self-checking bench for the FSK period demodulator
// Feeds timed carrier segments through a valid/stall driver. A built-in
// predictor tracks period accumulation, range checks, recovery of
// over-long periods, tone runs and statistics. A monitor checks each result
// against the oldest prediction under random idling on both sides and
// several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fsk_period_demodulator;
  import fpd_pkg::*;

  localparam int unsigned TW        = 16;
  localparam int unsigned SUM_MAX   = (1 << (TW + 2)) - 1;
  localparam int unsigned RUN_MAX   = 255;
  localparam int unsigned SETTLE    = 120;
  localparam int unsigned CYCLE_CAP = 600000;

  typedef struct {
    logic [8:0]  bit_count;
    logic        bit_value;
    logic        transition_seen;
    logic [31:0] tally [7];
  } decode_t;

  typedef struct {
    logic          level;
    logic [TW-1:0] length;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [TW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic line_level_i = 1'b0;
  logic [TW-1:0] segment_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [8:0] bit_count_o;
  logic bit_value_o, transition_seen_o;
  logic [31:0] cnt_o [7];

  fsk_period_demodulator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .line_level_i, .segment_length_i,
    .out_valid_o, .out_stall_i, .bit_count_o, .bit_value_o, .transition_seen_o,
    .count_short_rejects_o(cnt_o[0]), .count_long_rejects_o(cnt_o[1]),
    .count_long_recovered_o(cnt_o[2]), .count_accepted_o(cnt_o[3]),
    .count_high_class_o(cnt_o[4]), .count_low_class_o(cnt_o[5]),
    .count_transitions_o(cnt_o[6])
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow registers and decoder state
  int unsigned sh_short_time, sh_short_pulses, sh_long_time, sh_long_pulses;
  int unsigned period_sum, run_length;
  bit          last_tone;
  int unsigned tallies [7];
  // working tone settings after the possible swap
  int unsigned lo_t, hi_t, lo_p, hi_p, mid_t;
  bit          invert;

  segment_t pending_segments[$];
  decode_t  expected_decodes[$];
  int unsigned sender_idle_pct, receiver_idle_pct, errors, cycles;
  bit feed_hold;

  localparam int unsigned T_SHORT = 0, T_LONG = 1, T_RECOV = 2, T_ACC = 3;
  localparam int unsigned T_HIGH = 4, T_LOW = 5, T_TRANS = 6;

  function automatic void derive_tones();
    if (sh_short_time > sh_long_time) begin
      lo_t = sh_long_time;  lo_p = sh_long_pulses;
      hi_t = sh_short_time; hi_p = sh_short_pulses;
      invert = 1'b1;
    end else begin
      lo_t = sh_short_time; lo_p = sh_short_pulses;
      hi_t = sh_long_time;  hi_p = sh_long_pulses;
      invert = 1'b0;
    end
    if (lo_p == 0) lo_p = 1;
    if (hi_p == 0) hi_p = 1;
    mid_t = lo_t + (hi_t - lo_t) / 2;
  endfunction

  // Count one accepted period; close the run on a tone change.
  function automatic int unsigned count_period(input bit tone, inout bit val, inout bit seen);
    int unsigned n;
    tallies[T_ACC]++;
    if (tone) tallies[T_HIGH]++;
    else tallies[T_LOW]++;
    if (run_length < RUN_MAX) run_length++;
    if (tone == last_tone) return 0;
    n = run_length + 2;
    if (last_tone) begin
      n = n / hi_p; val = !invert;
    end else begin
      n = n / lo_p; val = invert;
    end
    seen = 1'b1;
    run_length = 0;
    last_tone = tone;
    tallies[T_TRANS]++;
    return n;
  endfunction

  function automatic decode_t decode_segment(input segment_t s);
    decode_t d;
    int unsigned bits, q;
    bit val, seen, done;
    bits = 0; val = 0; seen = 0; done = 0;
    derive_tones();
    if (s.level) begin
      period_sum = s.length;
    end else begin
      period_sum += s.length;
      if (period_sum > SUM_MAX) period_sum = SUM_MAX;
      if (period_sum < lo_t) begin
        tallies[T_SHORT]++;
        run_length = 0;
      end else if (period_sum >= hi_t) begin
        // try to split an over-long period into two, three or four
        for (int r = 2; r <= 4 && !done; r++) begin
          q = (period_sum + r / 2) / r;
          if (q >= lo_t && q < hi_t) begin
            for (int i = 0; i < r; i++) bits += count_period(q >= mid_t, val, seen);
            tallies[T_RECOV]++;
            done = 1'b1;
          end
        end
        if (!done) begin
          tallies[T_LONG]++;
          run_length = 0;
        end
      end else begin
        bits = count_period(period_sum >= mid_t, val, seen);
      end
    end
    d.bit_count = bits[8:0];
    d.bit_value = seen & val;
    d.transition_seen = seen;
    for (int k = 0; k < 7; k++) d.tally[k] = tallies[k];
    return d;
  endfunction

  // Driver: hold the request while stalled, advance from the queue otherwise.
  always @(posedge clk_i or negedge rst_ni) begin
    segment_t s, nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      line_level_i <= 1'b0;
      segment_length_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s.level = line_level_i;
        s.length = segment_length_i;
        expected_decodes.push_back(decode_segment(s));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (!feed_hold && pending_segments.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_segments.pop_front();
          in_valid_i <= 1'b1;
          line_level_i <= nxt.level;
          segment_length_i <= nxt.length;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each delivered result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    decode_t exp_d;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_decodes.size() == 0) begin
          $display("%0t: unexpected result, bit_count %0d", $time, bit_count_o);
          errors++;
        end else begin
          exp_d = expected_decodes.pop_front();
          if (exp_d.bit_count !== bit_count_o) begin
            $display("%0t: bit_count expected %0d actual %0d", $time, exp_d.bit_count,
                     bit_count_o);
            errors++;
          end
          if (exp_d.bit_value !== bit_value_o) begin
            $display("%0t: bit_value expected %0d actual %0d", $time, exp_d.bit_value,
                     bit_value_o);
            errors++;
          end
          if (exp_d.transition_seen !== transition_seen_o) begin
            $display("%0t: transition_seen expected %0d actual %0d", $time,
                     exp_d.transition_seen, transition_seen_o);
            errors++;
          end
          for (int k = 0; k < 7; k++) begin
            if (exp_d.tally[k] !== cnt_o[k]) begin
              $display("%0t: statistics counter %0d expected %0d actual %0d", $time, k,
                       exp_d.tally[k], cnt_o[k]);
              errors++;
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_segment(input bit level, input int unsigned length);
    segment_t s;
    s.level = level;
    s.length = (length > 65535) ? 65535 : length;
    pending_segments.push_back(s);
  endtask

  // One full period: high part then low part closing it.
  task automatic add_period(input int unsigned p);
    int unsigned h;
    h = $urandom_range(p);
    if (h > 65535) h = 65535;
    add_segment(1'b1, h);
    add_segment(1'b0, p - h);
  endtask

  // Drain: wait until every queued segment is fed and every result is back, then let the block settle.
  task automatic drain();
    feed_hold = 1'b0;
    while (pending_segments.size() != 0 || in_valid_i || expected_decodes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[TW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SHORT_TIME:   sh_short_time = value & 16'hFFFF;
      REG_SHORT_PULSES: sh_short_pulses = value & 8'hFF;
      REG_LONG_TIME:    sh_long_time = value & 16'hFFFF;
      REG_LONG_PULSES:  sh_long_pulses = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned st, sp, lt, lp);
    write_reg(REG_SHORT_TIME, st);
    write_reg(REG_SHORT_PULSES, sp);
    write_reg(REG_LONG_TIME, lt);
    write_reg(REG_LONG_PULSES, lp);
  endtask

  // Mostly well-formed tone runs with random jitter, some missing edges,
  // plus noise segments of random level and length.
  task automatic add_random_traffic(input int unsigned n);
    int unsigned added, span, p, run;
    bit tone;
    added = 0;
    derive_tones();
    span = (hi_t > lo_t) ? (hi_t - lo_t) / 4 : 0;
    while (added < n) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: add_segment($urandom_range(1), $urandom_range(65535));
          1: add_segment($urandom_range(1), 0);
          2: add_segment($urandom_range(1), 65535);
          default: add_segment(1'b0, $urandom_range(2 * hi_t + 1));
        endcase
        added++;
      end else begin
        tone = $urandom_range(1);
        run = $urandom_range(1, 14);
        for (int i = 0; i < run; i++) begin
          p = tone ? hi_t - 1 - $urandom_range(span) : lo_t + $urandom_range(span);
          if (hi_t <= lo_t) p = lo_t;
          if ($urandom_range(99) < 15) p = p * $urandom_range(2, 4);
          add_period(p);
          added += 2;
        end
      end
    end
  endtask

  initial begin
    sh_short_time = ShortTimeRst; sh_short_pulses = ShortPulsesRst;
    sh_long_time = LongTimeRst;   sh_long_pulses = LongPulsesRst;
    period_sum = 0; run_length = 0; last_tone = 0;
    for (int k = 0; k < 7; k++) tallies[k] = 0;
    errors = 0; cycles = 0; feed_hold = 1'b0;
    sender_idle_pct = 37; receiver_idle_pct = 75;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings (lo 64, hi 80, mid 72).
    add_segment(1'b1, 65535);
    add_segment(1'b0, 65535);
    add_segment(1'b0, 65535);
    add_segment(1'b0, 65535);   // accumulator comes just below its maximum here
    add_segment(1'b0, 0);
    add_segment(1'b1, 0);
    add_segment(1'b0, 10);      // too short
    add_period(64);             // short tone, lowest edge
    add_period(65);
    add_period(79);             // long tone, closes a short run
    add_period(72);             // midpoint counts as long tone
    add_period(70);
    add_period(140);            // recovered as two
    add_period(200);            // recovered as three
    add_period(260);            // recovered as four
    add_period(400);            // not recoverable
    add_segment(1'b1, 30);
    add_segment(1'b0, 20);
    add_segment(1'b0, 20);      // consecutive lows keep adding
    add_segment(1'b0, 75);
    drain();
    add_random_traffic(30);
    drain();

    // Swapped tones turn on invert mode.
    sender_idle_pct = 75; receiver_idle_pct = 37;
    configure(80, 5, 64, 6);
    add_random_traffic(30);
    drain();

    // Extremes: widest range, largest and zero pulses per bit.
    sender_idle_pct = 0; receiver_idle_pct = 0;
    configure(1, 255, 65535, 0);
    add_random_traffic(20);
    add_period(1);
    add_period(65534);
    add_period(0);
    drain();

    // Long like-tone run saturates the run counter.
    configure(10, 1, 40, 1);
    add_period(11);
    add_period(35);
    for (int i = 0; i < 130; i++) begin
      add_segment(1'b1, 11);
      add_segment(1'b0, 33);    // doubled period, counted twice
    end
    add_period(35);
    add_period(11);
    drain();

    // Swapped extremes, pulses written with upper bits set.
    configure(65535, 16'hFFFF, 1, 16'h1FF);
    add_random_traffic(20);
    drain();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
